/* hw/rtl/sddw_pkg.sv */
// Shared types and constants of the signed decimal digit writer.
`timescale 1ns / 1ps

package sddw_pkg;

    // Digit register addressing and codes.
    localparam logic [3:0] FIRST_ADDRESS = 4'd1;
    localparam logic [3:0] MINUS_CODE    = 4'd10;
    localparam logic [3:0] MAX_WRITES    = 4'd11;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // take a new value, start the conversion
        logic shift;       // one double-dabble step
        logic emit_digit;  // write the lowest BCD digit to the output register
        logic emit_sign;   // write the minus code to the output register
    } sddw_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic digit_final; // the digit now at the bottom is the last one emitted
        logic neg;         // the value being shown is negative
        logic out_free;    // the output register can take a write this cycle
    } sddw_status_t;

endpackage

/* hw/rtl/sddw_ctrl.sv */
// Controller state machine of the signed decimal digit writer.
`timescale 1ns / 1ps

module sddw_ctrl
    import sddw_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  sddw_status_t status,
    output sddw_cmd_t    cmd
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT_DIGIT,
        ST_EMIT_SIGN
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        in_ready       = 1'b0;
        cmd.load       = 1'b0;
        cmd.shift      = 1'b0;
        cmd.emit_digit = 1'b0;
        cmd.emit_sign  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(VALUE_WIDTH - 1))
                begin
                    state_next = ST_EMIT_DIGIT;
                end
            end
            ST_EMIT_DIGIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit_digit = 1'b1;
                    if (status.digit_final)
                    begin
                        state_next = status.neg ? ST_EMIT_SIGN : ST_IDLE;
                    end
                end
            end
            ST_EMIT_SIGN:
            begin
                if (status.out_free)
                begin
                    cmd.emit_sign = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* hw/rtl/sddw_datapath.sv */
// Datapath of the signed decimal digit writer: magnitude, BCD shifter and output register.
`timescale 1ns / 1ps

module sddw_datapath
    import sddw_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [VALUE_WIDTH-1:0] value,
    input  sddw_cmd_t              cmd,
    output sddw_status_t           status,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             out_address,
    output logic [3:0]             out_code,
    output logic                   out_last
);

    // Enough decimal digits for a magnitude of up to 2^(VALUE_WIDTH-1).
    localparam int NDIG  = (VALUE_WIDTH * 77) / 256 + 1;
    localparam int BCD_W = NDIG * 4;

    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [BCD_W-1:0]       bcd_reg, bcd_next;
    logic [BCD_W-1:0]       bcd_adj;
    logic                   neg_reg, neg_next;
    logic [3:0]             addr_reg, addr_next;
    logic                   valid_reg, valid_next;
    logic [3:0]             oaddr_reg, oaddr_next;
    logic [3:0]             ocode_reg, ocode_next;
    logic                   olast_reg, olast_next;
    logic                   rest_zero;
    logic                   at_cap;

    // Add three to every digit of five or more ahead of the shift.
    always_comb
    begin
        logic [3:0] d;
        for (int i = 0; i < NDIG; i++)
        begin
            d = bcd_reg[i*4 +: 4];
            bcd_adj[i*4 +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
        end
    end

    assign rest_zero = (bcd_reg[BCD_W-1:4] == '0);
    // The run is cut so that it never exceeds the write limit, sign included.
    assign at_cap    = neg_reg ? (addr_reg == MAX_WRITES - 4'd1) : (addr_reg == MAX_WRITES);

    assign status.digit_final = rest_zero || at_cap;
    assign status.neg         = neg_reg;
    assign status.out_free    = !valid_reg || out_ready;

    always_comb
    begin
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        addr_next  = addr_reg;
        valid_next = valid_reg && !out_ready;
        oaddr_next = oaddr_reg;
        ocode_next = ocode_reg;
        olast_next = olast_reg;
        if (cmd.load)
        begin
            neg_next  = value[VALUE_WIDTH-1];
            mag_next  = value[VALUE_WIDTH-1] ? (~value + VALUE_WIDTH'(1)) : value;
            bcd_next  = '0;
            addr_next = FIRST_ADDRESS;
        end
        if (cmd.shift)
        begin
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_WIDTH-1]};
            mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
        end
        if (cmd.emit_digit)
        begin
            valid_next = 1'b1;
            oaddr_next = addr_reg;
            ocode_next = bcd_reg[3:0];
            olast_next = !neg_reg && status.digit_final;
            bcd_next   = {4'd0, bcd_reg[BCD_W-1:4]};
            addr_next  = addr_reg + 4'd1;
        end
        if (cmd.emit_sign)
        begin
            valid_next = 1'b1;
            oaddr_next = addr_reg;
            ocode_next = MINUS_CODE;
            olast_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        neg_reg   <= neg_next;
        addr_reg  <= addr_next;
        oaddr_reg <= oaddr_next;
        ocode_reg <= ocode_next;
        olast_reg <= olast_next;
    end

    assign out_valid   = valid_reg;
    assign out_address = oaddr_reg;
    assign out_code    = ocode_reg;
    assign out_last    = olast_reg;

endmodule

/* hw/rtl/signed_decimal_digit_writer_core.sv */
// Top level of the signed decimal digit writer.
`timescale 1ns / 1ps
// Sequence: the value is loaded on accept and converted by the double-dabble shifter; the first
// digit write is then placed in the output register, where it waits until it is taken.
// A run holds 1 to 11 writes; the next value is accepted once the final write of the run has
// entered the output register. The shifter takes one magnitude bit per cycle, then one write a
// cycle while the output register is free (not stalled downstream).
// Reset (rst_n, asynchronous, active low) clears the controller and the output valid flag.

module signed_decimal_digit_writer_core
    import sddw_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input items. s_tdata: value (VALUE_WIDTH bits, signed), zero padding to whole bytes.
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((VALUE_WIDTH + 7) / 8)*8-1:0] s_tdata,
    // Result items. m_tdata: digit_address [3:0], digit_code [7:4]. m_tlast: last.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [7:0]                           m_tdata,
    output logic                                 m_tlast
);

    sddw_cmd_t    cmd;
    sddw_status_t status;
    logic [3:0]   digit_address;
    logic [3:0]   digit_code;

    // The controller sequences one value at a time: load, VALUE_WIDTH conversion
    // steps, then the digit writes and the optional minus sign.
    sddw_ctrl #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // The datapath holds the magnitude, the BCD digits and the output register.
    // The output register lets a new value be taken while the final write of
    // the previous run is still waiting downstream.
    sddw_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .value       (s_tdata[VALUE_WIDTH-1:0]),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_address (digit_address),
        .out_code    (digit_code),
        .out_last    (m_tlast)
    );

    assign m_tdata = {digit_code, digit_address};

endmodule

/* hw/rtl/sddw_checker.sv */
// Port-level assertions for the signed decimal digit writer, with their bind.
`timescale 1ns / 1ps

module sddw_checker
    import sddw_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // A stalled write holds its place and its contents.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled output write changed");

    // A value is converted over several cycles, so input is closed right after an accept.
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted during conversion");

    // Codes stay within the decimal digits and the minus sign.
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[7:4] <= MINUS_CODE)
        else $error("digit code out of range");

    // The minus sign always closes its run.
    a_sign_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[7:4] == MINUS_CODE) |-> m_tlast)
        else $error("minus sign not on the final write");

    // Addresses start at the first digit register and never fall to zero.
    a_addr_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] != 4'd0)
        else $error("digit address zero");

endmodule

bind signed_decimal_digit_writer_core sddw_checker u_sddw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
